@@ src/rps_pkg.sv @@
package rps_pkg;

	localparam int SideBits  = 8;
	localparam int PixBits   = 16;
	localparam int FracBits  = 14;
	localparam int IdxBits   = 7;
	localparam int DirBits   = 16;
	localparam int SizeBits  = 9;
	localparam int PosBits   = 25;
	localparam int BankAddr  = 2 * SideBits - 2;

	localparam logic [1:0] REG_ROWS = 2'd0;
	localparam logic [1:0] REG_COLS = 2'd1;
	localparam logic [1:0] REG_DIRX = 2'd2;
	localparam logic [1:0] REG_DIRY = 2'd3;

	localparam logic REQ_WRITE  = 1'b0;
	localparam logic REQ_SAMPLE = 1'b1;

	typedef struct packed {
		logic                req_type;
		logic [SideBits-1:0] pix_row;
		logic [SideBits-1:0] pix_col;
		logic [PixBits-1:0]  pix_value;
		logic [IdxBits-1:0]  sample_index;
	} in_item_t;

	typedef struct packed {
		logic [PixBits-1:0] sample_value;
		logic               used_bilinear;
		logic               index_ok;
		logic [IdxBits-1:0] echo_index;
	} out_item_t;

	typedef struct packed {
		logic                   we;
		logic [BankAddr-1:0]    waddr;
		logic [PixBits-1:0]     wdata;
		logic [BankAddr-1:0]    raddr;
	} bank_ctl_t;

endpackage

@@ src/rps_bank.sv @@
module rps_bank
	import rps_pkg::*;
(
	input  logic               clk,
	input  bank_ctl_t          ctl,
	output logic [PixBits-1:0] rdata
);

	logic [PixBits-1:0] mem [2**BankAddr];

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[ctl.waddr] <= ctl.wdata;
		end
		rdata <= mem[ctl.raddr];
	end

endmodule

@@ src/rps_addr.sv @@
module rps_addr
	import rps_pkg::*;
(
	input  logic                clk,
	input  logic [SizeBits-1:0] num_rows,
	input  logic [SizeBits-1:0] num_cols,
	input  logic [DirBits-1:0]  dir_x,
	input  logic [DirBits-1:0]  dir_y,
	input  logic                en,
	input  logic [IdxBits-1:0]  idx,
	output logic [SideBits-1:0] yr_s2,
	output logic [SideBits-1:0] xc_s2,
	output logic [FracBits-1:0] ax_s2,
	output logic [FracBits-1:0] ay_s2,
	output logic                bil_s2,
	output logic                ok_s2
);

	logic [SizeBits-1:0] rows, cols, lim;
	logic signed [PosBits-1:0] sx, sy;
	logic signed [PosBits-1:0] px_s1, py_s1;
	logic ok_s1;
	logic [SizeBits-1:0] rows_s1, cols_s1;

	always_comb begin
		rows = (num_rows == '0) ? SizeBits'(1)
			: (num_rows > SizeBits'(256)) ? SizeBits'(256) : num_rows;
		cols = (num_cols == '0) ? SizeBits'(1)
			: (num_cols > SizeBits'(256)) ? SizeBits'(256) : num_cols;
		lim = ((rows < cols) ? rows : cols) >> 1;
		sx = PosBits'($signed({1'b0, idx})) * PosBits'($signed(dir_x));
		sy = PosBits'($signed({1'b0, idx})) * PosBits'($signed(dir_y));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= sx + $signed({2'b0, cols >> 1, {FracBits{1'b0}}});
			py_s1 <= sy + $signed({2'b0, rows >> 1, {FracBits{1'b0}}});
			ok_s1 <= {2'b0, idx} < lim;
			rows_s1 <= rows;
			cols_s1 <= cols;
		end
	end

	logic [PosBits-FracBits-1:0] xi, yi, xn, yn;
	logic [PosBits-1:0] xrnd, yrnd;
	logic bil;

	always_comb begin
		xi = px_s1[PosBits-1:FracBits];
		yi = py_s1[PosBits-1:FracBits];
		xrnd = px_s1 + PosBits'(1 << (FracBits - 1));
		yrnd = py_s1 + PosBits'(1 << (FracBits - 1));
		bil = !px_s1[PosBits-1] && !py_s1[PosBits-1] && xi != '0 && yi != '0
			&& (xi + 1'b1) < 11'(cols_s1) && (yi + 1'b1) < 11'(rows_s1);
		xn = xrnd[PosBits-1:FracBits];
		yn = yrnd[PosBits-1:FracBits];
		if (px_s1[PosBits-1]) xn = '0;
		else if (xn > 11'(cols_s1) - 1'b1) xn = 11'(cols_s1) - 1'b1;
		if (py_s1[PosBits-1]) yn = '0;
		else if (yn > 11'(rows_s1) - 1'b1) yn = 11'(rows_s1) - 1'b1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bil_s2 <= bil && ok_s1;
			ok_s2 <= ok_s1;
			xc_s2 <= bil ? xi[SideBits-1:0] : xn[SideBits-1:0];
			yr_s2 <= bil ? yi[SideBits-1:0] : yn[SideBits-1:0];
			ax_s2 <= bil ? px_s1[FracBits-1:0] : '0;
			ay_s2 <= bil ? py_s1[FracBits-1:0] : '0;
		end
	end

endmodule

@@ src/rps_blend.sv @@
module rps_blend
	import rps_pkg::*;
(
	input  logic               clk,
	input  logic               en,
	input  logic [PixBits-1:0] p00,
	input  logic [PixBits-1:0] p01,
	input  logic [PixBits-1:0] p10,
	input  logic [PixBits-1:0] p11,
	input  logic [FracBits-1:0] ax,
	input  logic [FracBits-1:0] ay,
	output logic [PixBits-1:0] val
);

	localparam int W = PixBits + FracBits + 1;
	localparam int W2 = 2 * FracBits + PixBits + 2;

	logic [W-1:0] a_s1, b_s1;
	logic [FracBits:0] ax_s1;
	logic [W2-1:0] m0, m1;
	logic [W2-1:0] sum_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= W'(p00) * W'((FracBits+1)'(1 << FracBits) - ay) + W'(p10) * W'(ay);
			b_s1 <= W'(p01) * W'((FracBits+1)'(1 << FracBits) - ay) + W'(p11) * W'(ay);
			ax_s1 <= {1'b0, ax};
		end
	end

	always_comb begin
		m0 = W2'(a_s1) * W2'((FracBits+1)'(1 << FracBits) - ax_s1);
		m1 = W2'(b_s1) * W2'(ax_s1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2 <= m0 + m1 + W2'(1 << (2 * FracBits - 1));
		end
	end

	assign val = sum_s2[2*FracBits +: PixBits];

endmodule

@@ src/radial_profile_sampler_top.sv @@
// channel | valid     | stall     | payload
// in      | in_valid  | in_stall  | in_data  (in_item_t)
// out     | out_valid | out_stall | out_data (out_item_t)
// one item per cycle while out_stall does not hold the pipeline; a sample runs from transfer to the output register
// through the pipeline: position, address, bank read, two blend multiply stages, output
// the pipeline advances as a whole while the output register is free or taken
// reset clears valid flags and loads the configuration defaults; the frame store is undefined until written
// a pixel write is registered in the first stage and lands in its bank from there, between the reads of its neighbors
module radial_profile_sampler_top
	import rps_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [DirBits-1:0]  cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  in_item_t            in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output out_item_t           out_data
);

	logic [SizeBits-1:0] rows_q, cols_q;
	logic [DirBits-1:0]  dirx_q, diry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= SizeBits'(256);
			cols_q <= SizeBits'(256);
			dirx_q <= DirBits'(16384);
			diry_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROWS: rows_q <= cfg_data[SizeBits-1:0];
				REG_COLS: cols_q <= cfg_data[SizeBits-1:0];
				REG_DIRX: dirx_q <= cfg_data;
				REG_DIRY: diry_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic adv;
	logic [5:0] v_q;
	logic [IdxBits-1:0] idx_s1, idx_s2, idx_s3, idx_s4, idx_s5;
	logic bil_s3, bil_s4, bil_s5, ok_s3, ok_s4, ok_s5;
	logic [SideBits-1:0] yr_s2, xc_s2, yr_s3_q, xc_s3_q, yr_rd, xc_rd;
	logic [FracBits-1:0] ax_s2, ay_s2, ax_s3, ay_s3;
	logic bil_s2, ok_s2;
	logic wr, wr_s1;
	logic [SideBits-1:0] wrow_s1, wcol_s1;
	logic [PixBits-1:0] wval_s1;
	logic [1:0] xsel_s3;

	assign adv = !(v_q[5] && out_stall);
	assign in_stall = !adv;
	assign wr = in_valid && adv && in_data.req_type == REQ_WRITE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
			wr_s1 <= 1'b0;
		end else if (adv) begin
			v_q <= {v_q[4:0], in_valid && in_data.req_type == REQ_SAMPLE};
			wr_s1 <= wr;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			wrow_s1 <= in_data.pix_row;
			wcol_s1 <= in_data.pix_col;
			wval_s1 <= in_data.pix_value;
		end
	end

	rps_addr u_addr (
		.clk(clk), .num_rows(rows_q), .num_cols(cols_q), .dir_x(dirx_q), .dir_y(diry_q),
		.en(adv), .idx(in_data.sample_index),
		.yr_s2(yr_s2), .xc_s2(xc_s2), .ax_s2(ax_s2), .ay_s2(ay_s2),
		.bil_s2(bil_s2), .ok_s2(ok_s2)
	);

	// bank b = {row parity, col parity}
	logic [PixBits-1:0] rd [4];
	logic [SideBits-1:0] y1, x1;

	// a held pipeline repeats the read of the third stage
	assign yr_rd = adv ? yr_s2 : yr_s3_q;
	assign xc_rd = adv ? xc_s2 : xc_s3_q;
	assign y1 = yr_rd + 1'b1;
	assign x1 = xc_rd + 1'b1;

	for (genvar b = 0; b < 4; b++) begin : g_bank
		localparam logic [1:0] BankId = 2'(b);
		bank_ctl_t ctl;
		logic [SideBits-1:0] ry, rx;
		always_comb begin
			ry = (yr_rd[0] == BankId[1]) ? yr_rd : y1;
			rx = (xc_rd[0] == BankId[0]) ? xc_rd : x1;
			ctl.we = wr_s1 && adv && wrow_s1[0] == BankId[1] && wcol_s1[0] == BankId[0];
			ctl.waddr = {wrow_s1[SideBits-1:1], wcol_s1[SideBits-1:1]};
			ctl.wdata = wval_s1;
			ctl.raddr = {ry[SideBits-1:1], rx[SideBits-1:1]};
		end
		rps_bank u_bank (.clk(clk), .ctl(ctl), .rdata(rd[b]));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s1 <= in_data.sample_index;
			idx_s2 <= idx_s1;
			idx_s3 <= idx_s2;
			idx_s4 <= idx_s3;
			idx_s5 <= idx_s4;
			bil_s3 <= bil_s2; ok_s3 <= ok_s2;
			bil_s4 <= bil_s3; ok_s4 <= ok_s3;
			bil_s5 <= bil_s4; ok_s5 <= ok_s4;
			ax_s3 <= ax_s2; ay_s3 <= ay_s2;
			xsel_s3 <= {xc_s2[0], yr_s2[0]};
			yr_s3_q <= yr_s2;
			xc_s3_q <= xc_s2;
		end
	end

	logic [PixBits-1:0] p00, p01, p10, p11, bl;
	logic [PixBits-1:0] near_s4, near_s5;

	always_comb begin
		p00 = rd[{xsel_s3[0], xsel_s3[1]}];
		p01 = rd[{xsel_s3[0], ~xsel_s3[1]}];
		p10 = rd[{~xsel_s3[0], xsel_s3[1]}];
		p11 = rd[{~xsel_s3[0], ~xsel_s3[1]}];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			near_s4 <= p00;
			near_s5 <= near_s4;
		end
	end

	rps_blend u_blend (
		.clk(clk), .en(adv), .p00(p00), .p01(p01), .p10(p10), .p11(p11),
		.ax(ax_s3), .ay(ay_s3), .val(bl)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data.sample_value <= !ok_s5 ? '0 : bil_s5 ? bl : near_s5;
			out_data.used_bilinear <= bil_s5;
			out_data.index_ok <= ok_s5;
			out_data.echo_index <= idx_s5;
		end
	end

	assign out_valid = v_q[5];

endmodule
